// File: rtl/core/hmtn_pkg.sv
// shared types and fixed widths for the heightmap triangle normal mesher
// no dependencies
package hmtn_pkg;

    localparam int HIN_W  = 24;   // height sample width
    localparam int POS_W  = 17;   // grid position, unsigned Q1.16
    localparam int NRM_W  = 16;   // normal component, signed Q1.15
    localparam int Q_W    = 15;   // normal magnitude bits
    localparam int VEC_W  = 48;   // scaled edge vector component
    localparam int LEN_W  = 96;   // squared length
    localparam int MB_W   = 64;   // multiplier b operand
    localparam int PROD_W = 128;  // multiplier result
    localparam int ACC_W  = 160;  // multiplier accumulator
    localparam int CH_W   = 32;   // multiplier chunk

    typedef enum logic [2:0] {
        T_IDLE,
        T_RD,
        T_VEC,
        T_N1,
        T_N1W,
        T_N2,
        T_N2W,
        T_OUT
    } t_top_state;

    typedef enum logic [3:0] {
        N_IDLE,
        N_SQX,
        N_SQXW,
        N_SQY,
        N_SQYW,
        N_ODD,
        N_TST,
        N_TSTW,
        N_FIN
    } t_nrm_state;

    typedef enum logic [1:0] {
        C_X,
        C_Y,
        C_Z
    } t_comp;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } t_normal;

endpackage

// File: rtl/core/hmtn_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module hmtn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/hmtn_mul.sv
// iterative wide multiplier: 96 x 64 bits from six 32 x 32 partial products
// depends on hmtn_pkg
module hmtn_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hmtn_pkg::LEN_W-1:0]   i_a,
    input  logic [hmtn_pkg::MB_W-1:0]    i_b,
    output logic                         o_done,
    output logic [hmtn_pkg::PROD_W-1:0]  o_prod
);

    logic [hmtn_pkg::LEN_W-1:0]  r_a;
    logic [hmtn_pkg::MB_W-1:0]   r_b;
    logic                        r_busy;
    logic                        r_pv;
    logic                        r_done;
    logic [2:0]                  r_idx;
    logic [2*hmtn_pkg::CH_W-1:0] r_pp;
    logic [1:0]                  r_sh;
    logic [hmtn_pkg::ACC_W-1:0]  r_acc;

    logic [1:0]                  a_sel;
    logic                        b_sel;
    logic [hmtn_pkg::CH_W-1:0]   a_ch;
    logic [hmtn_pkg::CH_W-1:0]   b_ch;
    logic [2*hmtn_pkg::CH_W-1:0] pp;
    logic [hmtn_pkg::ACC_W-1:0]  addend;

    always_comb begin
        case (r_idx)
            3'd0: begin a_sel = 2'd0; b_sel = 1'b0; end
            3'd1: begin a_sel = 2'd1; b_sel = 1'b0; end
            3'd2: begin a_sel = 2'd2; b_sel = 1'b0; end
            3'd3: begin a_sel = 2'd0; b_sel = 1'b1; end
            3'd4: begin a_sel = 2'd1; b_sel = 1'b1; end
            3'd5: begin a_sel = 2'd2; b_sel = 1'b1; end
            default: begin a_sel = 2'd0; b_sel = 1'b0; end
        endcase
        case (a_sel)
            2'd0: a_ch = r_a[31:0];
            2'd1: a_ch = r_a[63:32];
            2'd2: a_ch = r_a[95:64];
            default: a_ch = r_a[31:0];
        endcase
        b_ch = b_sel ? r_b[63:32] : r_b[31:0];
        pp   = 64'(a_ch) * 64'(b_ch);
        case (r_sh)
            2'd0: addend = {96'd0, r_pp};
            2'd1: addend = {64'd0, r_pp, 32'd0};
            2'd2: addend = {32'd0, r_pp, 64'd0};
            2'd3: addend = {r_pp, 96'd0};
            default: addend = {96'd0, r_pp};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_idx  <= 3'd0;
            end else if (r_busy) begin
                r_pv <= (r_idx != 3'd6);
                if (r_idx == 3'd6) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end else begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp <= pp;
        r_sh <= a_sel + {1'b0, b_sel};
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && r_pv) begin
            r_acc <= r_acc + addend;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[hmtn_pkg::PROD_W-1:0];

endmodule

// File: rtl/core/hmtn_norm.sv
// unit normal of (vx, vy, 65536), rounded to Q1.15, one result bit per test
// depends on hmtn_pkg and hmtn_mul
module hmtn_norm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [hmtn_pkg::VEC_W-1:0] i_vx,
    input  logic signed [hmtn_pkg::VEC_W-1:0] i_vy,
    output logic                              o_done,
    output hmtn_pkg::t_normal                 o_norm
);

    localparam int VW = hmtn_pkg::VEC_W;
    localparam int LW = hmtn_pkg::LEN_W;
    localparam int BW = hmtn_pkg::MB_W;
    localparam int PW = hmtn_pkg::PROD_W;
    localparam int QW = hmtn_pkg::Q_W;
    localparam int NW = hmtn_pkg::NRM_W;

    hmtn_pkg::t_nrm_state r_state, n_state;
    hmtn_pkg::t_comp      r_comp;
    hmtn_pkg::t_normal    r_norm;

    logic [VW-1:0] r_ax, r_ay;
    logic          r_negx, r_negy;
    logic [LW-1:0] r_sqx, r_sqy, r_len2;
    logic [QW-1:0] r_q;
    logic [3:0]    r_bit;
    logic [31:0]   r_oddsq;

    logic          mul_start;
    logic [LW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic          mul_done;
    logic [PW-1:0] mul_prod;

    logic [QW-1:0] cand;
    logic [QW:0]   odd;
    logic [PW-1:0] lim;
    logic [QW-1:0] q_new;
    logic [NW-1:0] q_sgn;
    logic          neg;

    hmtn_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_comb begin
        cand = r_q | (QW'(1) << r_bit);
        odd  = {cand, 1'b0} - (QW+1)'(1);
        case (r_comp)
            hmtn_pkg::C_X: lim = {r_sqx, 32'd0};
            hmtn_pkg::C_Y: lim = {r_sqy, 32'd0};
            hmtn_pkg::C_Z: lim = PW'(1) << 64;
            default: lim = PW'(1) << 64;
        endcase
        q_new = (mul_prod <= lim) ? cand : r_q;
        case (r_comp)
            hmtn_pkg::C_X: neg = r_negx;
            hmtn_pkg::C_Y: neg = r_negy;
            default: neg = 1'b0;
        endcase
        q_sgn = neg ? -NW'(q_new) : NW'(q_new);
    end

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = LW'(r_ax);
        mul_b     = BW'(r_ax);
        case (r_state)
            hmtn_pkg::N_IDLE: begin
                if (i_start) n_state = hmtn_pkg::N_SQX;
            end
            hmtn_pkg::N_SQX: begin
                mul_start = 1'b1;
                n_state   = hmtn_pkg::N_SQXW;
            end
            hmtn_pkg::N_SQXW: begin
                if (mul_done) n_state = hmtn_pkg::N_SQY;
            end
            hmtn_pkg::N_SQY: begin
                mul_start = 1'b1;
                mul_a     = LW'(r_ay);
                mul_b     = BW'(r_ay);
                n_state   = hmtn_pkg::N_SQYW;
            end
            hmtn_pkg::N_SQYW: begin
                if (mul_done) n_state = hmtn_pkg::N_ODD;
            end
            hmtn_pkg::N_ODD: begin
                n_state = hmtn_pkg::N_TST;
            end
            hmtn_pkg::N_TST: begin
                mul_start = 1'b1;
                mul_a     = r_len2;
                mul_b     = BW'(r_oddsq);
                n_state   = hmtn_pkg::N_TSTW;
            end
            hmtn_pkg::N_TSTW: begin
                if (mul_done) begin
                    if (r_bit == 4'd0 && r_comp == hmtn_pkg::C_Z) n_state = hmtn_pkg::N_FIN;
                    else n_state = hmtn_pkg::N_ODD;
                end
            end
            hmtn_pkg::N_FIN: begin
                n_state = hmtn_pkg::N_IDLE;
            end
            default: n_state = hmtn_pkg::N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hmtn_pkg::N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            hmtn_pkg::N_IDLE: begin
                r_ax   <= i_vx[VW-1] ? VW'(-i_vx) : VW'(i_vx);
                r_ay   <= i_vy[VW-1] ? VW'(-i_vy) : VW'(i_vy);
                r_negx <= i_vx[VW-1];
                r_negy <= i_vy[VW-1];
            end
            hmtn_pkg::N_SQXW: begin
                if (mul_done) r_sqx <= mul_prod[LW-1:0];
            end
            hmtn_pkg::N_SQYW: begin
                if (mul_done) begin
                    r_sqy  <= mul_prod[LW-1:0];
                    r_len2 <= r_sqx + mul_prod[LW-1:0] + (LW'(1) << 32);
                    r_comp <= hmtn_pkg::C_X;
                    r_bit  <= 4'd14;
                    r_q    <= '0;
                end
            end
            hmtn_pkg::N_ODD: begin
                r_oddsq <= 32'(odd) * 32'(odd);
            end
            hmtn_pkg::N_TSTW: begin
                if (mul_done) begin
                    if (r_bit == 4'd0) begin
                        r_q   <= '0;
                        r_bit <= 4'd14;
                        case (r_comp)
                            hmtn_pkg::C_X: begin
                                r_norm.x <= q_sgn;
                                r_comp   <= hmtn_pkg::C_Y;
                            end
                            hmtn_pkg::C_Y: begin
                                r_norm.y <= q_sgn;
                                r_comp   <= hmtn_pkg::C_Z;
                            end
                            default: r_norm.z <= q_sgn;
                        endcase
                    end else begin
                        r_q   <= q_new;
                        r_bit <= r_bit - 4'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == hmtn_pkg::N_FIN);
    assign o_norm = r_norm;

endmodule

// File: rtl/core/heightmap_triangle_normal_mesher.sv
// heightmap grid mesher: six vertices with flat normals per completed cell
// a sample is taken only in idle; o_stall holds off the next one until the last is done,
// and a sample that completes a cell waits for two normals and for its six vertices to leave (i_stall can hold them);
// the cell time is set by the shared 32 x 32 multiplier in the normal unit (45 tests per normal)
// reset: synchronous active low, clears counters and the left and upper-left heights; line buffer is not cleared
module heightmap_triangle_normal_mesher #(
    parameter int GRID_SEGMENTS = 1023,
    parameter int HEIGHT_BITS   = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [hmtn_pkg::HIN_W-1:0]  i_height,
    input  logic                               i_first,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [hmtn_pkg::POS_W-1:0]         o_pos_x,
    output logic [hmtn_pkg::POS_W-1:0]         o_pos_y,
    output logic signed [hmtn_pkg::HIN_W-1:0]  o_pos_z,
    output logic signed [hmtn_pkg::NRM_W-1:0]  o_norm_x,
    output logic signed [hmtn_pkg::NRM_W-1:0]  o_norm_y,
    output logic signed [hmtn_pkg::NRM_W-1:0]  o_norm_z,
    output logic                               o_cell_end
);

    localparam int HB    = HEIGHT_BITS;
    localparam int ZW    = hmtn_pkg::HIN_W;
    localparam int PSW   = hmtn_pkg::POS_W;
    localparam int VW    = hmtn_pkg::VEC_W;
    localparam int DEPTH = GRID_SEGMENTS + 1;
    localparam int CW    = $clog2(DEPTH);
    localparam int RW    = $clog2(4 * GRID_SEGMENTS);
    localparam int TWO_S = 2 * GRID_SEGMENTS;
    localparam int K_Q   = 131072 / (2 * GRID_SEGMENTS);
    localparam int K_R   = 131072 % (2 * GRID_SEGMENTS);
    localparam logic [CW-1:0]       S_C = CW'(GRID_SEGMENTS);
    localparam logic [RW-1:0]       S_R = RW'(GRID_SEGMENTS);
    localparam logic signed [VW-1:0] S_K = VW'(GRID_SEGMENTS);

    hmtn_pkg::t_top_state r_state, n_state;

    logic [CW-1:0]  r_col, r_row;
    logic [PSW-1:0] r_cq, r_cpq, r_rq, r_rpq;
    logic [RW-1:0]  r_cr, r_rr;
    logic signed [HB-1:0] r_h, r_ur, r_ul, r_lf;
    logic signed [VW-1:0] r_v1x, r_v1y, r_v2x, r_v2y;
    hmtn_pkg::t_normal r_n1, r_n2;
    logic [2:0]     r_vtx;

    logic                 r_ovalid;
    logic [PSW-1:0]       r_px, r_py;
    logic signed [ZW-1:0] r_pz;
    hmtn_pkg::t_normal    r_on;
    logic                 r_end;

    logic signed [HB-1:0] h_in;
    logic [CW-1:0]  rd_addr;
    logic [HB-1:0]  rd_data;
    logic           emit;
    logic           out_free;
    logic           load;
    logic           commit;
    logic           nrm_start;
    logic           nrm_done;
    hmtn_pkg::t_normal nrm;
    logic signed [VW-1:0] nvx, nvy;

    logic [RW-1:0]  cr_sum, rr_sum;
    logic [PSW-1:0] cq_inc, rq_inc;
    logic [RW-1:0]  cr_inc, rr_inc;

    logic [PSW-1:0]       sel_px, sel_py;
    logic signed [HB-1:0] sel_z;
    hmtn_pkg::t_normal    sel_n;

    assign h_in     = HB'(i_height);
    assign rd_addr  = i_first ? '0 : r_col;
    assign emit     = (r_col != '0) && (r_row != '0);
    assign out_free = !r_ovalid || !i_stall;
    assign load     = (r_state == hmtn_pkg::T_OUT) && out_free;
    assign commit   = ((r_state == hmtn_pkg::T_RD) && !emit) || (load && r_vtx == 3'd5);
    assign nrm_start = (r_state == hmtn_pkg::T_N1) || (r_state == hmtn_pkg::T_N2);
    assign nvx      = (r_state == hmtn_pkg::T_N2) ? r_v2x : r_v1x;
    assign nvy      = (r_state == hmtn_pkg::T_N2) ? r_v2y : r_v1y;

    hmtn_ram #(
        .WIDTH (HB),
        .DEPTH (DEPTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (r_state == hmtn_pkg::T_RD),
        .i_waddr (r_col),
        .i_wdata (r_h),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    hmtn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nrm_start),
        .i_vx    (nvx),
        .i_vy    (nvy),
        .o_done  (nrm_done),
        .o_norm  (nrm)
    );

    // grid position step: q + 131072 / 2S with the remainder carried
    always_comb begin
        cr_sum = r_cr + RW'(K_R);
        if (cr_sum >= RW'(TWO_S)) begin
            cr_inc = cr_sum - RW'(TWO_S);
            cq_inc = r_cq + PSW'(K_Q) + PSW'(1);
        end else begin
            cr_inc = cr_sum;
            cq_inc = r_cq + PSW'(K_Q);
        end
        rr_sum = r_rr + RW'(K_R);
        if (rr_sum >= RW'(TWO_S)) begin
            rr_inc = rr_sum - RW'(TWO_S);
            rq_inc = r_rq + PSW'(K_Q) + PSW'(1);
        end else begin
            rr_inc = rr_sum;
            rq_inc = r_rq + PSW'(K_Q);
        end
    end

    always_comb begin
        case (r_vtx)
            3'd0: begin sel_px = r_cpq; sel_py = r_rpq; sel_z = r_ul; sel_n = r_n1; end
            3'd1: begin sel_px = r_cq;  sel_py = r_rpq; sel_z = r_ur; sel_n = r_n1; end
            3'd2: begin sel_px = r_cpq; sel_py = r_rq;  sel_z = r_lf; sel_n = r_n1; end
            3'd3: begin sel_px = r_cpq; sel_py = r_rq;  sel_z = r_lf; sel_n = r_n2; end
            3'd4: begin sel_px = r_cq;  sel_py = r_rpq; sel_z = r_ur; sel_n = r_n2; end
            default: begin sel_px = r_cq; sel_py = r_rq; sel_z = r_h; sel_n = r_n2; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hmtn_pkg::T_IDLE: if (i_valid) n_state = hmtn_pkg::T_RD;
            hmtn_pkg::T_RD:   n_state = emit ? hmtn_pkg::T_VEC : hmtn_pkg::T_IDLE;
            hmtn_pkg::T_VEC:  n_state = hmtn_pkg::T_N1;
            hmtn_pkg::T_N1:   n_state = hmtn_pkg::T_N1W;
            hmtn_pkg::T_N1W:  if (nrm_done) n_state = hmtn_pkg::T_N2;
            hmtn_pkg::T_N2:   n_state = hmtn_pkg::T_N2W;
            hmtn_pkg::T_N2W:  if (nrm_done) n_state = hmtn_pkg::T_OUT;
            hmtn_pkg::T_OUT:  if (load && r_vtx == 3'd5) n_state = hmtn_pkg::T_IDLE;
            default: n_state = hmtn_pkg::T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hmtn_pkg::T_IDLE;
            r_ovalid <= 1'b0;
            r_vtx    <= 3'd0;
            r_col    <= '0;
            r_row    <= '0;
            r_cq     <= '0;
            r_cpq    <= '0;
            r_cr     <= S_R;
            r_rq     <= '0;
            r_rpq    <= '0;
            r_rr     <= S_R;
            r_ul     <= '0;
            r_lf     <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (load) begin
                r_vtx <= (r_vtx == 3'd5) ? 3'd0 : r_vtx + 3'd1;
            end
            if (r_state == hmtn_pkg::T_IDLE && i_valid && i_first) begin
                r_col <= '0;
                r_cq  <= '0;
                r_cr  <= S_R;
                r_row <= '0;
                r_rq  <= '0;
                r_rr  <= S_R;
            end
            if (commit) begin
                // on the no-cell path the upper sample is still on the ram output
                r_ul <= (r_state == hmtn_pkg::T_RD) ? rd_data : r_ur;
                r_lf <= r_h;
                if (r_col >= S_C) begin
                    r_col <= '0;
                    r_cq  <= '0;
                    r_cr  <= S_R;
                    if (r_row >= S_C) begin
                        r_row <= '0;
                        r_rq  <= '0;
                        r_rr  <= S_R;
                    end else begin
                        r_row <= r_row + CW'(1);
                        r_rpq <= r_rq;
                        r_rq  <= rq_inc;
                        r_rr  <= rr_inc;
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                    r_cpq <= r_cq;
                    r_cq  <= cq_inc;
                    r_cr  <= cr_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hmtn_pkg::T_IDLE && i_valid) begin
            r_h <= h_in;
        end
        if (r_state == hmtn_pkg::T_RD) begin
            r_ur <= rd_data;
        end
        if (r_state == hmtn_pkg::T_VEC) begin
            r_v1x <= (VW'(r_ul) - VW'(r_ur)) * S_K;
            r_v1y <= (VW'(r_ul) - VW'(r_lf)) * S_K;
            r_v2x <= (VW'(r_lf) - VW'(r_h)) * S_K;
            r_v2y <= (VW'(r_ur) - VW'(r_h)) * S_K;
        end
        if (r_state == hmtn_pkg::T_N1W && nrm_done) begin
            r_n1 <= nrm;
        end
        if (r_state == hmtn_pkg::T_N2W && nrm_done) begin
            r_n2 <= nrm;
        end
        if (load) begin
            r_px  <= sel_px;
            r_py  <= sel_py;
            r_pz  <= ZW'(sel_z);
            r_on  <= sel_n;
            r_end <= (r_vtx == 3'd5);
        end
    end

    assign o_stall    = (r_state != hmtn_pkg::T_IDLE);
    assign o_valid    = r_ovalid;
    assign o_pos_x    = r_px;
    assign o_pos_y    = r_py;
    assign o_pos_z    = r_pz;
    assign o_norm_x   = r_on.x;
    assign o_norm_y   = r_on.y;
    assign o_norm_z   = r_on.z;
    assign o_cell_end = r_end;

endmodule

// File: dv/heightmap_triangle_normal_mesher_test.sv
// testbench for heightmap_triangle_normal_mesher: raster height samples in,
// six vertices with flat normals per completed cell out, checked against a local predictor
// depends on hmtn_pkg and the mesher rtl
`timescale 1ns / 100ps

module heightmap_triangle_normal_mesher_test;

    localparam int SEGS = 1023;
    localparam int STALL_LIMIT = 20000;
    localparam int POS_W = hmtn_pkg::POS_W;
    localparam int HIN_W = hmtn_pkg::HIN_W;
    localparam int NRM_W = hmtn_pkg::NRM_W;

    typedef struct {
        logic [POS_W-1:0]        px;
        logic [POS_W-1:0]        py;
        logic signed [HIN_W-1:0] pz;
        hmtn_pkg::t_normal       n;
        logic                    last;
    } t_vertex;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [HIN_W-1:0]   i_height;
    logic                      i_first;
    logic                      o_valid;
    logic                      i_stall;
    logic [POS_W-1:0]          o_pos_x;
    logic [POS_W-1:0]          o_pos_y;
    logic signed [HIN_W-1:0]   o_pos_z;
    logic signed [NRM_W-1:0]   o_norm_x;
    logic signed [NRM_W-1:0]   o_norm_y;
    logic signed [NRM_W-1:0]   o_norm_z;
    logic                      o_cell_end;

    heightmap_triangle_normal_mesher #(
        .GRID_SEGMENTS(SEGS),
        .HEIGHT_BITS  (24)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_height  (i_height),
        .i_first   (i_first),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_pos_x   (o_pos_x),
        .o_pos_y   (o_pos_y),
        .o_pos_z   (o_pos_z),
        .o_norm_x  (o_norm_x),
        .o_norm_y  (o_norm_y),
        .o_norm_z  (o_norm_z),
        .o_cell_end(o_cell_end)
    );

    // predictor state
    logic signed [HIN_W-1:0] prev_row [SEGS+1];
    logic signed [HIN_W-1:0] left_h;
    logic signed [HIN_W-1:0] upleft_h;
    int                      col_pos;
    int                      row_pos;

    t_vertex     vertex_q[$];
    int          mismatches;
    bit          quiet;
    int          stall_left;
    int          idle_count;
    int          height_mode;
    int          height_base;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [127:0] abs_wide(longint a);
        return (a < 0) ? 128'(-a) : 128'(a);
    endfunction

    function automatic logic signed [NRM_W-1:0] unit_q15(longint a, logic [127:0] len2);
        logic [127:0] lim;
        logic [127:0] odd;
        int           q;
        int           cand;
        lim = (abs_wide(a) * abs_wide(a)) << 32;
        q = 0;
        for (int b = 14; b >= 0; b--) begin
            cand = q | (1 << b);
            odd = 128'(2 * cand - 1);
            if (len2 * odd * odd <= lim)
                q = cand;
        end
        return (a < 0) ? NRM_W'(-q) : NRM_W'(q);
    endfunction

    function automatic hmtn_pkg::t_normal flat_normal(longint vx, longint vy);
        logic [127:0]      len2;
        hmtn_pkg::t_normal n;
        len2 = abs_wide(vx) * abs_wide(vx) + abs_wide(vy) * abs_wide(vy) + (128'd1 << 32);
        n.x = unit_q15(vx, len2);
        n.y = unit_q15(vy, len2);
        n.z = unit_q15(65536, len2);
        return n;
    endfunction

    function automatic logic [POS_W-1:0] grid_coord(int c);
        return POS_W'((longint'(c) * 131072 + SEGS) / (2 * SEGS));
    endfunction

    task automatic push_vertex(int c, int r, logic signed [HIN_W-1:0] z,
                               hmtn_pkg::t_normal n, logic e);
        t_vertex v;
        v.px = grid_coord(c);
        v.py = grid_coord(r);
        v.pz = z;
        v.n = n;
        v.last = e;
        vertex_q.push_back(v);
    endtask

    task automatic predict_sample(logic signed [HIN_W-1:0] h, logic f);
        int                      c;
        int                      r;
        logic signed [HIN_W-1:0] ur;
        hmtn_pkg::t_normal       n1;
        hmtn_pkg::t_normal       n2;
        if (f) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        ur = prev_row[c];
        if (c > 0 && r > 0) begin
            n1 = flat_normal(-SEGS * (longint'(ur) - longint'(upleft_h)),
                             -SEGS * (longint'(left_h) - longint'(upleft_h)));
            n2 = flat_normal(SEGS * (longint'(left_h) - longint'(h)),
                             SEGS * (longint'(ur) - longint'(h)));
            push_vertex(c - 1, r - 1, upleft_h, n1, 1'b0);
            push_vertex(c, r - 1, ur, n1, 1'b0);
            push_vertex(c - 1, r, left_h, n1, 1'b0);
            push_vertex(c - 1, r, left_h, n2, 1'b0);
            push_vertex(c, r - 1, ur, n2, 1'b0);
            push_vertex(c, r, h, n2, 1'b1);
        end
        upleft_h = ur;
        left_h = h;
        prev_row[c] = h;
        if (c >= SEGS) begin
            col_pos = 0;
            row_pos = (r >= SEGS) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // one request, with an optional idle burst ahead of it
    task automatic send_sample(logic signed [HIN_W-1:0] h, logic f);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_height <= h;
        i_first <= f;
        do @(posedge i_clk); while (o_stall);
        predict_sample(h, f);
    endtask

    function automatic logic signed [HIN_W-1:0] pick_height();
        case (height_mode)
            0: return HIN_W'($urandom);
            1: return HIN_W'(height_base + $urandom_range(0, 64) - 32);
            default: return HIN_W'(height_base);
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [HIN_W-1:0] ext [4];
        ext[0] = 24'sh7FFFFF;
        ext[1] = 24'sh800000;
        ext[2] = 24'sh000000;
        ext[3] = 24'shFFFFFF;
        for (int c = 0; c <= SEGS; c++)
            send_sample((c < 8) ? ext[c % 4] : HIN_W'(c), c == 0);
        // flat cells, steep cells, small slopes
        send_sample(ext[0], 1'b0);
        send_sample(ext[1], 1'b0);
        send_sample(ext[0], 1'b0);
        send_sample(ext[2], 1'b0);
        send_sample(ext[3], 1'b0);
        send_sample(ext[1], 1'b0);
        send_sample(ext[2], 1'b0);
        send_sample(ext[0], 1'b0);
        send_sample(24'sd9, 1'b0);
        send_sample(24'sd10, 1'b0);
        send_sample(24'sd11, 1'b0);
        send_sample(24'sd11, 1'b0);
        send_sample(24'sd1000, 1'b0);
        send_sample(-24'sd1000, 1'b0);
    endtask

    // continues the current row, so every request completes a cell
    task automatic test_random_grid(int cells);
        height_base = int'($urandom) >>> 8;
        for (int k = 0; k <= cells; k++) begin
            height_mode = $urandom_range(0, 9) < 4 ? 0 : $urandom_range(1, 2);
            if ($urandom_range(0, 15) == 0)
                height_base = int'($urandom) >>> 8;
            send_sample(pick_height(), 1'b0);
        end
    endtask

    task automatic test_quiet_grid();
        quiet = 1'b1;
        test_random_grid(60);
    endtask

    // receive side: stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_vertex v;
        if (i_rst_n && o_valid && !i_stall) begin
            if (vertex_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%0d y=%0d", o_pos_x, o_pos_y);
            end else begin
                v = vertex_q.pop_front();
                if (o_pos_x !== v.px || o_pos_y !== v.py || o_pos_z !== v.pz ||
                    o_norm_x !== v.n.x || o_norm_y !== v.n.y || o_norm_z !== v.n.z ||
                    o_cell_end !== v.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"vertex mismatch exp %0d %0d %0d n %0d %0d %0d e %0d,",
                                  " got %0d %0d %0d n %0d %0d %0d e %0d"},
                                 v.px, v.py, v.pz, v.n.x, v.n.y, v.n.z, v.last,
                                 o_pos_x, o_pos_y, o_pos_z, o_norm_x, o_norm_y, o_norm_z,
                                 o_cell_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("heightmap_triangle_normal_mesher_test: errors");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        mismatches = 0;
        quiet = 1'b0;
        stall_left = 0;
        idle_count = 0;
        height_mode = 0;
        height_base = 0;
        left_h = '0;
        upleft_h = '0;
        col_pos = 0;
        row_pos = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_height <= '0;
        i_first <= 1'b0;
        i_stall <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_random_grid(130);
        test_quiet_grid();
        i_valid <= 1'b0;
        wait (vertex_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && vertex_q.size() == 0)
            $display("heightmap_triangle_normal_mesher_test: clean");
        else
            $display("heightmap_triangle_normal_mesher_test: errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/hmtn_pkg.sv
rtl/core/hmtn_ram.sv
rtl/core/hmtn_mul.sv
rtl/core/hmtn_norm.sv
rtl/core/heightmap_triangle_normal_mesher.sv
dv/heightmap_triangle_normal_mesher_test.sv
